// File: rtl/par_pkg.sv
package par_pkg;

	localparam int COORD_W = 32;
	localparam int ANGLE_W = 32;
	localparam int BA_W = 32;
	localparam int CW = 34;
	localparam int FRAC_W = 30;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int CORDIC_STAGES_DEF = 20;
	localparam int CORDIC_MAX = 32;
	localparam int COORD_MIN = 16;

	// inverse cordic gain in q4.30
	localparam logic signed [CW-1:0] X_INIT = 34'sd652032874;

	// angle reduction: q16.16 degrees to a 32-bit binary angle
	localparam logic [16:0] TURN_OFS = 17'd352;
	localparam logic [15:0] RECIP_360 = 16'd46603;
	localparam logic [8:0] DEG_360 = 9'd360;
	localparam logic [29:0] ROUND_OFS = 30'd22;
	localparam logic [23:0] TURN_PER_DEG = 24'd11930464;
	localparam logic [29:0] RECIP_45 = 30'd763549741;
	localparam logic [5:0] DIV_45 = 6'd45;
	localparam logic signed [BA_W-1:0] QUARTER_POS = 32'sh4000_0000;
	localparam logic signed [BA_W-1:0] QUARTER_NEG = 32'shC000_0000;

	typedef enum logic [1:0] {
		AXIS_NONE,
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
		logic [1:0] axis_sel;
		logic signed [ANGLE_W-1:0] angle_deg;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		axis_t axis;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0] z;
		logic flip;
		point_t pt;
	} ang_t;

	typedef struct packed {
		logic signed [CW-1:0] c;
		logic signed [CW-1:0] s;
		point_t pt;
	} trig_t;

	function automatic int coord_eff(input int w);
		int r;
		r = w;
		if (r > COORD_W) r = COORD_W;
		if (r < COORD_MIN) r = COORD_MIN;
		return r;
	endfunction

	// atan(2^-i) in binary-angle units
	function automatic logic [BA_W-1:0] atan_ba(input logic [4:0] idx);
		logic [BA_W-1:0] r;
		case (idx)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/par_stream_if.sv
interface par_stream_if #(
	parameter type item_t = logic
);
	logic valid;
	logic ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/principal_axis_rotation_unit.sv
// channel   dir  payload                                        handshake
// points    in   in_x, in_y, in_z, axis_sel, angle_deg          valid / ready
// rotated   out  out_x, out_y, out_z, saturated                 valid / ready
//
// one item per cycle while the output is not stalled
// the pipeline is the unrolled cordic, one register stage per iteration,
// plus six stages of angle reduction, one fold-back stage and three of multiply/round
// reset clears only the stage valid bits; there is no clearing pass
// a stall holds only the full stages behind it; empty stages keep filling,
// so new items are taken while a finished result waits at the output
module principal_axis_rotation_unit #(
	parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = par_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	par_stream_if.sink points,
	par_stream_if.source rotated
);
	par_pkg::point_t pt_in;
	logic ang_valid, ang_ready;
	logic trig_valid, trig_ready;
	par_pkg::ang_t ang_data;
	par_pkg::trig_t trig_data;
	par_pkg::out_item_t res_data;

	assign pt_in = '{
		x: points.data.in_x,
		y: points.data.in_y,
		z: points.data.in_z,
		axis: par_pkg::axis_t'(points.data.axis_sel)
	};

	par_angle u_angle (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(points.valid),
		.in_ready(points.ready),
		.angle(points.data.angle_deg),
		.pt(pt_in),
		.out_valid(ang_valid),
		.out_ready(ang_ready),
		.out_data(ang_data)
	);

	par_cordic #(
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(ang_valid),
		.in_ready(ang_ready),
		.in_data(ang_data),
		.out_valid(trig_valid),
		.out_ready(trig_ready),
		.out_data(trig_data)
	);

	par_combine #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_combine (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(trig_valid),
		.in_ready(trig_ready),
		.in_data(trig_data),
		.out_valid(rotated.valid),
		.out_ready(rotated.ready),
		.out_data(res_data)
	);

	assign rotated.data = res_data;

`ifndef SYNTHESIS
	localparam int CW_EFF = par_pkg::coord_eff(COORD_WIDTH);
	localparam logic signed [par_pkg::COORD_W-1:0] OUT_HI =
		par_pkg::COORD_W'((64'sd1 <<< (CW_EFF - 1)) - 64'sd1);
	localparam logic signed [par_pkg::COORD_W-1:0] OUT_LO = ~OUT_HI;

	// an empty output stage means every stage behind it can move
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rotated.valid |-> points.ready)
		else $error("input blocked with an empty output stage");

	a_sink_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rotated.ready |-> points.ready)
		else $error("input blocked while the sink is ready");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		rotated.valid |->
		(rotated.data.out_x <= OUT_HI) && (rotated.data.out_x >= OUT_LO) &&
		(rotated.data.out_y <= OUT_HI) && (rotated.data.out_y >= OUT_LO) &&
		(rotated.data.out_z <= OUT_HI) && (rotated.data.out_z >= OUT_LO))
		else $error("result coordinate outside the coordinate range");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rotated.valid && rotated.data.saturated |->
		(rotated.data.out_x == OUT_HI) || (rotated.data.out_x == OUT_LO) ||
		(rotated.data.out_y == OUT_HI) || (rotated.data.out_y == OUT_LO) ||
		(rotated.data.out_z == OUT_HI) || (rotated.data.out_z == OUT_LO))
		else $error("saturated flag without a clipped coordinate");
`endif

endmodule

// File: rtl/par_angle.sv
module par_angle (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [par_pkg::ANGLE_W-1:0] angle,
	input par_pkg::point_t pt,
	output logic out_valid,
	input logic out_ready,
	output par_pkg::ang_t out_data
);
	localparam int CW = par_pkg::CW;
	localparam int BA_W = par_pkg::BA_W;

	logic [6:1] take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1: whole degrees plus offset, quotient estimate by 360
	logic [16:0] turn_hi;
	logic [32:0] q_prod;
	logic [16:0] hi_s1;
	logic [15:0] lo_s1;
	logic [7:0] qe_s1;
	par_pkg::point_t pt_s1;

	// stage 2: remainder in degrees
	logic [16:0] qx360;
	logic [16:0] rem;
	logic [8:0] rv;
	logic [8:0] rv_s2;
	logic [15:0] lo_s2;
	par_pkg::point_t pt_s2;

	// stage 3: split of the divide by 360
	logic [29:0] w;
	logic [32:0] hi_turn;
	logic [29:0] w_s3;
	logic [BA_W-1:0] hi_s3;
	par_pkg::point_t pt_s3;

	// stage 4: quotient estimate by 45
	logic [59:0] w_prod;
	logic [29:0] w_s4;
	logic [23:0] qe_s4;
	logic [BA_W-1:0] hi_s4;
	par_pkg::point_t pt_s4;

	// stage 5: binary angle
	logic [29:0] qx45;
	logic [29:0] rr;
	logic [BA_W-1:0] ba;
	logic [BA_W-1:0] ba_s5;
	par_pkg::point_t pt_s5;

	// stage 6: fold into +-90 degrees
	logic fold;
	logic [BA_W-1:0] zf;
	logic signed [CW-1:0] z_s6;
	logic flip_s6;
	par_pkg::point_t pt_s6;

	assign take[6] = ~v_s6 | out_ready;
	assign take[5] = ~v_s5 | take[6];
	assign take[4] = ~v_s4 | take[5];
	assign take[3] = ~v_s3 | take[4];
	assign take[2] = ~v_s2 | take[3];
	assign take[1] = ~v_s1 | take[2];
	assign in_ready = take[1];

	// offset by a multiple of a full turn so the value is non-negative
	assign turn_hi = {1'b0, ~angle[par_pkg::ANGLE_W-1], angle[30:16]} + par_pkg::TURN_OFS;
	assign q_prod = turn_hi * par_pkg::RECIP_360;

	assign qx360 = qe_s1 * par_pkg::DEG_360;
	assign rem = hi_s1 - qx360;
	assign rv = (rem >= 17'(par_pkg::DEG_360)) ? 9'(rem - 17'(par_pkg::DEG_360)) : 9'(rem);

	assign w = 30'({rv_s2, 5'b0}) + 30'({lo_s2, 13'b0}) + par_pkg::ROUND_OFS;
	assign hi_turn = rv_s2 * par_pkg::TURN_PER_DEG;

	assign w_prod = w_s3 * par_pkg::RECIP_45;

	assign qx45 = qe_s4 * par_pkg::DIV_45;
	assign rr = w_s4 - qx45;
	assign ba = hi_s4 + BA_W'(qe_s4) + {31'b0, rr >= 30'(par_pkg::DIV_45)};

	assign fold = ($signed(ba_s5) > par_pkg::QUARTER_POS) ||
		($signed(ba_s5) < par_pkg::QUARTER_NEG);
	assign zf = fold ? {~ba_s5[BA_W-1], ba_s5[BA_W-2:0]} : ba_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (take[1]) v_s1 <= in_valid;
			if (take[2]) v_s2 <= v_s1;
			if (take[3]) v_s3 <= v_s2;
			if (take[4]) v_s4 <= v_s3;
			if (take[5]) v_s5 <= v_s4;
			if (take[6]) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (take[1] && in_valid) begin
			hi_s1 <= turn_hi;
			lo_s1 <= angle[15:0];
			qe_s1 <= q_prod[31:24];
			pt_s1 <= pt;
		end
		if (take[2] && v_s1) begin
			rv_s2 <= rv;
			lo_s2 <= lo_s1;
			pt_s2 <= pt_s1;
		end
		if (take[3] && v_s2) begin
			w_s3 <= w;
			hi_s3 <= hi_turn[BA_W-1:0];
			pt_s3 <= pt_s2;
		end
		if (take[4] && v_s3) begin
			w_s4 <= w_s3;
			qe_s4 <= w_prod[58:35];
			hi_s4 <= hi_s3;
			pt_s4 <= pt_s3;
		end
		if (take[5] && v_s4) begin
			ba_s5 <= ba;
			pt_s5 <= pt_s4;
		end
		if (take[6] && v_s5) begin
			z_s6 <= CW'($signed(zf));
			flip_s6 <= fold;
			pt_s6 <= pt_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_data = '{z: z_s6, flip: flip_s6, pt: pt_s6};

endmodule

// File: rtl/par_cordic.sv
module par_cordic #(
	parameter int CORDIC_STAGES = par_pkg::CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input par_pkg::ang_t in_data,
	output logic out_valid,
	input logic out_ready,
	output par_pkg::trig_t out_data
);
	localparam int CW = par_pkg::CW;
	localparam int N_ITER = (CORDIC_STAGES > par_pkg::CORDIC_MAX) ?
		par_pkg::CORDIC_MAX : CORDIC_STAGES;

	logic [N_ITER:0] take;
	logic [N_ITER-1:0] v_s;
	logic signed [CW-1:0] x_s [N_ITER];
	logic signed [CW-1:0] y_s [N_ITER];
	logic signed [CW-1:0] z_s [N_ITER];
	logic flip_s [N_ITER];
	par_pkg::point_t pt_s [N_ITER];

	logic v_sn;
	logic signed [CW-1:0] cos_sn;
	logic signed [CW-1:0] sin_sn;
	par_pkg::point_t pt_sn;

	for (genvar k = 0; k < N_ITER; k++) begin : g_iter
		logic signed [CW-1:0] xi, yi, zi;
		logic fi;
		logic vi;
		par_pkg::point_t pi;

		if (k == 0) begin : g_first
			assign xi = par_pkg::X_INIT;
			assign yi = '0;
			assign zi = in_data.z;
			assign fi = in_data.flip;
			assign pi = in_data.pt;
			assign vi = in_valid;
		end else begin : g_next
			assign xi = x_s[k-1];
			assign yi = y_s[k-1];
			assign zi = z_s[k-1];
			assign fi = flip_s[k-1];
			assign pi = pt_s[k-1];
			assign vi = v_s[k-1];
		end

		assign take[k] = ~v_s[k] | take[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (take[k]) begin
				v_s[k] <= vi;
			end
		end

		always_ff @(posedge clk) begin
			if (take[k] && vi) begin
				if (!zi[CW-1]) begin
					x_s[k] <= xi - (yi >>> k);
					y_s[k] <= yi + (xi >>> k);
					z_s[k] <= zi - CW'(par_pkg::atan_ba(5'(k)));
				end else begin
					x_s[k] <= xi + (yi >>> k);
					y_s[k] <= yi - (xi >>> k);
					z_s[k] <= zi + CW'(par_pkg::atan_ba(5'(k)));
				end
				flip_s[k] <= fi;
				pt_s[k] <= pi;
			end
		end
	end

	assign take[N_ITER] = ~v_sn | out_ready;
	assign in_ready = take[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sn <= 1'b0;
		end else if (take[N_ITER]) begin
			v_sn <= v_s[N_ITER-1];
		end
	end

	// undo the half-turn fold
	always_ff @(posedge clk) begin
		if (take[N_ITER] && v_s[N_ITER-1]) begin
			cos_sn <= flip_s[N_ITER-1] ? -x_s[N_ITER-1] : x_s[N_ITER-1];
			sin_sn <= flip_s[N_ITER-1] ? -y_s[N_ITER-1] : y_s[N_ITER-1];
			pt_sn <= pt_s[N_ITER-1];
		end
	end

	assign out_valid = v_sn;
	assign out_data = '{c: cos_sn, s: sin_sn, pt: pt_sn};

endmodule

// File: rtl/par_combine.sv
module par_combine #(
	parameter int COORD_WIDTH = par_pkg::COORD_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input par_pkg::trig_t in_data,
	output logic out_valid,
	input logic out_ready,
	output par_pkg::out_item_t out_data
);
	localparam int PW = par_pkg::COORD_W;
	localparam int CW_EFF = par_pkg::coord_eff(COORD_WIDTH);
	localparam int FRAC_W = par_pkg::FRAC_W;
	localparam int PROD_W = PW + par_pkg::CW;
	localparam int SUM_W = PROD_W + 1;
	localparam int RW = SUM_W - FRAC_W;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'(64'sd1 <<< (FRAC_W - 1));
	localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (CW_EFF - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

	logic [3:1] take;
	logic v_s1, v_s2, v_s3;

	// stage 1: sign extension, operand select, products
	logic signed [CW_EFF-1:0] xn, yn, zn;
	logic signed [PW-1:0] ex, ey, ez, p, q;
	logic signed [PROD_W-1:0] pc, qs, ps, qc;
	logic signed [PROD_W-1:0] pc_s1, qs_s1, ps_s1, qc_s1;
	logic signed [PW-1:0] ex_s1, ey_s1, ez_s1;
	par_pkg::axis_t axis_s1;

	// stage 2: sums and rounding
	logic signed [SUM_W-1:0] t1, t2;
	logic signed [RW-1:0] r1_s2, r2_s2;
	logic signed [PW-1:0] ex_s2, ey_s2, ez_s2;
	par_pkg::axis_t axis_s2;

	// stage 3: saturation and output register
	logic signed [RW-1:0] sat1, sat2;
	logic clip1, clip2;
	par_pkg::out_item_t res;
	par_pkg::out_item_t res_s3;

	assign take[3] = ~v_s3 | out_ready;
	assign take[2] = ~v_s2 | take[3];
	assign take[1] = ~v_s1 | take[2];
	assign in_ready = take[1];

	assign xn = in_data.pt.x[CW_EFF-1:0];
	assign yn = in_data.pt.y[CW_EFF-1:0];
	assign zn = in_data.pt.z[CW_EFF-1:0];
	assign ex = PW'(xn);
	assign ey = PW'(yn);
	assign ez = PW'(zn);

	// rotation in the plane (p, q): p' = p*c - q*s, q' = p*s + q*c
	always_comb begin
		case (in_data.pt.axis)
			par_pkg::AXIS_X: begin
				p = ey;
				q = ez;
			end
			par_pkg::AXIS_Y: begin
				p = ez;
				q = ex;
			end
			default: begin
				p = ex;
				q = ey;
			end
		endcase
	end

	assign pc = p * in_data.c;
	assign qs = q * in_data.s;
	assign ps = p * in_data.s;
	assign qc = q * in_data.c;

	assign t1 = SUM_W'(pc_s1) - SUM_W'(qs_s1) + RND;
	assign t2 = SUM_W'(ps_s1) + SUM_W'(qc_s1) + RND;

	always_comb begin
		sat1 = r1_s2;
		clip1 = 1'b0;
		if (r1_s2 > SAT_HI) begin
			sat1 = SAT_HI;
			clip1 = 1'b1;
		end else if (r1_s2 < SAT_LO) begin
			sat1 = SAT_LO;
			clip1 = 1'b1;
		end
		sat2 = r2_s2;
		clip2 = 1'b0;
		if (r2_s2 > SAT_HI) begin
			sat2 = SAT_HI;
			clip2 = 1'b1;
		end else if (r2_s2 < SAT_LO) begin
			sat2 = SAT_LO;
			clip2 = 1'b1;
		end
	end

	always_comb begin
		res.saturated = clip1 | clip2;
		case (axis_s2)
			par_pkg::AXIS_X: begin
				res.out_x = ex_s2;
				res.out_y = sat1[PW-1:0];
				res.out_z = sat2[PW-1:0];
			end
			par_pkg::AXIS_Y: begin
				res.out_x = sat2[PW-1:0];
				res.out_y = ey_s2;
				res.out_z = sat1[PW-1:0];
			end
			par_pkg::AXIS_Z: begin
				res.out_x = sat1[PW-1:0];
				res.out_y = sat2[PW-1:0];
				res.out_z = ez_s2;
			end
			default: begin
				res.out_x = ex_s2;
				res.out_y = ey_s2;
				res.out_z = ez_s2;
				res.saturated = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take[1]) v_s1 <= in_valid;
			if (take[2]) v_s2 <= v_s1;
			if (take[3]) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take[1] && in_valid) begin
			pc_s1 <= pc;
			qs_s1 <= qs;
			ps_s1 <= ps;
			qc_s1 <= qc;
			ex_s1 <= ex;
			ey_s1 <= ey;
			ez_s1 <= ez;
			axis_s1 <= in_data.pt.axis;
		end
		if (take[2] && v_s1) begin
			r1_s2 <= t1[SUM_W-1:FRAC_W];
			r2_s2 <= t2[SUM_W-1:FRAC_W];
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;
			ez_s2 <= ez_s1;
			axis_s2 <= axis_s1;
		end
		if (take[3] && v_s2) begin
			res_s3 <= res;
		end
	end

	assign out_valid = v_s3;
	assign out_data = res_s3;

endmodule

// File: bench/rotation_checker.sv
`timescale 1ns / 100ps

module rotation_checker
	import par_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input in_item_t in_data,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_data,
	output int mismatches,
	output int pending,
	output int results_seen,
	output int clipped_seen
);

	localparam int WIDTH_EFF = COORD_WIDTH > 32 ? 32 : (COORD_WIDTH < 16 ? 16 : COORD_WIDTH);
	localparam longint TURN_Q16 = 64'd23592960;
	localparam longint GAIN_Q30 = 64'd652032874;
	localparam longint QUARTER = 64'd1073741824;
	localparam int REPORT_MAX = 10;

	localparam longint ATAN_TAB [32] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
		163, 81, 41, 20, 10, 5, 3, 1, 1, 0
	};

	out_item_t rotated_due[$];

	function automatic longint sign_ext(input logic [31:0] raw, input int w);
		longint t;
		t = longint'({32'd0, raw});
		t = t <<< (64 - w);
		return t >>> (64 - w);
	endfunction

	// binary angle, quadrant fold, then rotation-mode cordic
	function automatic void cordic_trig(input logic [31:0] ang, output longint c,
			output longint s);
		longint a, r, ba, z, x, y, nx;
		logic flip;
		a = sign_ext(ang, 32);
		r = a % TURN_Q16;
		if (r < 0) r = r + TURN_Q16;
		ba = ((r <<< 16) + 180) / 360;
		ba = ba & 64'hFFFF_FFFF;
		z = (ba >= 64'h8000_0000) ? ba - 64'h1_0000_0000 : ba;
		flip = 1'b0;
		if (z > QUARTER) begin
			z = z - 2 * QUARTER;
			flip = 1'b1;
		end else if (z < -QUARTER) begin
			z = z + 2 * QUARTER;
			flip = 1'b1;
		end
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_TAB[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// q30 products, round half up, clip to the coordinate range
	function automatic longint mix_round(input longint p, input longint k1, input longint q,
			input longint k2, inout logic clip);
		longint t, v, hi, lo;
		t = p * k1 + q * k2 + (64'sd1 <<< 29);
		v = t >>> 30;
		hi = (64'sd1 <<< (WIDTH_EFF - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			clip = 1'b1;
			return hi;
		end
		if (v < lo) begin
			clip = 1'b1;
			return lo;
		end
		return v;
	endfunction

	function automatic out_item_t rotate_point(input in_item_t it);
		out_item_t res;
		longint x, y, z, c, s, ox, oy, oz;
		logic clip;
		x = sign_ext(it.in_x, WIDTH_EFF);
		y = sign_ext(it.in_y, WIDTH_EFF);
		z = sign_ext(it.in_z, WIDTH_EFF);
		ox = x;
		oy = y;
		oz = z;
		clip = 1'b0;
		cordic_trig(it.angle_deg, c, s);
		case (axis_t'(it.axis_sel))
			AXIS_X: begin
				oy = mix_round(y, c, z, -s, clip);
				oz = mix_round(y, s, z, c, clip);
			end
			AXIS_Y: begin
				ox = mix_round(x, c, z, s, clip);
				oz = mix_round(x, -s, z, c, clip);
			end
			AXIS_Z: begin
				ox = mix_round(x, c, y, -s, clip);
				oy = mix_round(x, s, y, c, clip);
			end
			default: begin
			end
		endcase
		res.out_x = ox[31:0];
		res.out_y = oy[31:0];
		res.out_z = oz[31:0];
		res.saturated = clip;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			rotated_due.delete();
			mismatches <= 0;
			pending <= 0;
			results_seen <= 0;
			clipped_seen <= 0;
		end else begin
			if (in_valid && in_ready) rotated_due.push_back(rotate_point(in_data));
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (rotated_due.size() == 0) begin
					if (mismatches < REPORT_MAX)
						$display("%0t: result with no item waiting: x=%h y=%h z=%h sat=%b",
							$realtime, out_data.out_x, out_data.out_y, out_data.out_z,
							out_data.saturated);
					mismatches <= mismatches + 1;
				end else begin
					want = rotated_due.pop_front();
					if (want.saturated) clipped_seen <= clipped_seen + 1;
					if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
							out_data.out_z !== want.out_z ||
							out_data.saturated !== want.saturated) begin
						if (mismatches < REPORT_MAX)
							$display("%0t: mismatch exp x=%h y=%h z=%h sat=%b got x=%h y=%h z=%h sat=%b",
								$realtime, want.out_x, want.out_y, want.out_z, want.saturated,
								out_data.out_x, out_data.out_y, out_data.out_z,
								out_data.saturated);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= rotated_due.size();
		end
	end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import par_pkg::*;

	localparam int COORD_WIDTH = COORD_WIDTH_DEF;
	localparam int CORDIC_STAGES = CORDIC_STAGES_DEF;
	localparam int DEG = 65536;
	localparam int RANDOM_ITEMS = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = CORDIC_STAGES + 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic gaps_on = 1'b0;
	logic stalls_on = 1'b0;
	int cycles = 0;
	int sent_by_axis [4];
	int mismatches, pending, results_seen, clipped_seen;

	par_stream_if #(.item_t(in_item_t)) points_ch ();
	par_stream_if #(.item_t(out_item_t)) rotated_ch ();

	principal_axis_rotation_unit #(
		.COORD_WIDTH(COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_ch),
		.rotated(rotated_ch)
	);

	rotation_checker #(
		.COORD_WIDTH(COORD_WIDTH),
		.CORDIC_STAGES(CORDIC_STAGES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(points_ch.valid),
		.in_ready(points_ch.ready),
		.in_data(points_ch.data),
		.out_valid(rotated_ch.valid),
		.out_ready(rotated_ch.ready),
		.out_data(rotated_ch.data),
		.mismatches(mismatches),
		.pending(pending),
		.results_seen(results_seen),
		.clipped_seen(clipped_seen)
	);

	always #10 clk = ~clk;

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL principal_axis_rotation_unit");
		$finish;
	end

	// receiver stalls in bursts
	initial begin
		int hold;
		hold = 0;
		rotated_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stalls_on && hold == 0 && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 7);
			if (hold > 0) begin
				rotated_ch.ready <= 1'b0;
				hold--;
			end else begin
				rotated_ch.ready <= arst_n;
			end
		end
	end

	function automatic in_item_t mk_point(input int x, input int y, input int z,
			input axis_t ax, input int ang);
		in_item_t it;
		it.in_x = x;
		it.in_y = y;
		it.in_z = z;
		it.axis_sel = ax;
		it.angle_deg = ang;
		return it;
	endfunction

	function automatic int rand_coord();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = int'($urandom_range(0, 200 * DEG)) - 100 * DEG;
			2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
				: 32'h8000_0000 + $urandom_range(0, 255);
			default: v = $signed($urandom) >>> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	function automatic int rand_angle();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = int'($urandom_range(0, 1440 * DEG)) - 720 * DEG;
			2: v = (int'($urandom_range(0, 16)) - 8) * 90 * DEG + int'($urandom_range(0, 4)) - 2;
			default: v = int'($urandom_range(0, 2 * DEG)) - DEG;
		endcase
		return v;
	endfunction

	// one item; valid stays up so the next item can follow back to back
	task automatic send_point(input in_item_t it);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			points_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		points_ch.valid <= 1'b1;
		points_ch.data <= it;
		@(posedge clk);
		while (!points_ch.ready) @(posedge clk);
		sent_by_axis[it.axis_sel]++;
	endtask

	task automatic wait_drained();
		points_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		in_item_t it;
		for (int k = 0; k < n; k++) begin
			it = mk_point(rand_coord(), rand_coord(), rand_coord(),
				axis_t'($urandom_range(0, 3)), rand_angle());
			send_point(it);
		end
	endtask

	initial begin
		in_item_t dir_items [$];
		points_ch.valid = 1'b0;
		points_ch.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// axis none passes the point through, extremes included
		dir_items.push_back(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 0, AXIS_NONE, 45 * DEG));
		dir_items.push_back(mk_point(32'h8000_0000, 32'h7FFF_FFFF, -1, AXIS_NONE, 32'h8000_0000));
		// zero angle still goes through the cordic
		dir_items.push_back(mk_point(DEG, 2 * DEG, 3 * DEG, AXIS_X, 0));
		dir_items.push_back(mk_point(DEG, 2 * DEG, 3 * DEG, AXIS_Y, 0));
		dir_items.push_back(mk_point(DEG, 2 * DEG, 3 * DEG, AXIS_Z, 0));
		// quarter turns and the fold-back region
		dir_items.push_back(mk_point(DEG, -DEG, DEG, AXIS_X, 90 * DEG));
		dir_items.push_back(mk_point(DEG, -DEG, DEG, AXIS_Y, 180 * DEG));
		dir_items.push_back(mk_point(DEG, -DEG, DEG, AXIS_Z, 270 * DEG));
		dir_items.push_back(mk_point(5 * DEG, 7 * DEG, -3 * DEG, AXIS_Z, -90 * DEG));
		dir_items.push_back(mk_point(5 * DEG, 7 * DEG, -3 * DEG, AXIS_X, 360 * DEG));
		dir_items.push_back(mk_point(5 * DEG, 7 * DEG, -3 * DEG, AXIS_Y, 23592959));
		dir_items.push_back(mk_point(5 * DEG, 7 * DEG, -3 * DEG, AXIS_Z, -1));
		// angle field extremes
		dir_items.push_back(mk_point(100 * DEG, 0, 0, AXIS_Z, 32'h7FFF_FFFF));
		dir_items.push_back(mk_point(0, 100 * DEG, 0, AXIS_X, 32'h8000_0000));
		// overflow clips to the bounds, then tiny and zero points
		dir_items.push_back(mk_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, AXIS_Z, 45 * DEG));
		dir_items.push_back(mk_point(0, 32'h8000_0000, 32'h8000_0000, AXIS_X, 45 * DEG));
		dir_items.push_back(mk_point(32'h7FFF_FFFF, 0, 32'h8000_0000, AXIS_Y, 135 * DEG));
		dir_items.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			AXIS_Z, 180 * DEG));
		dir_items.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			AXIS_Y, 225 * DEG));
		dir_items.push_back(mk_point(-1, -1, -1, AXIS_X, 315 * DEG));
		dir_items.push_back(mk_point(1, 1, 1, AXIS_Y, 30 * DEG));
		dir_items.push_back(mk_point(0, 0, 0, AXIS_Z, 77 * DEG));

		gaps_on = 1'b1;
		stalls_on = 1'b1;
		foreach (dir_items[k]) send_point(dir_items[k]);
		wait_drained();

		send_random(150);
		wait_drained();
		// a stretch with no idling on either side
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_random(50);
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		send_random(120);
		// last part runs at full rate
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_random(RANDOM_ITEMS - 320);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items (none %0d, x %0d, y %0d, z %0d), checked %0d results",
			sent_by_axis[0] + sent_by_axis[1] + sent_by_axis[2] + sent_by_axis[3],
			sent_by_axis[0], sent_by_axis[1], sent_by_axis[2], sent_by_axis[3], results_seen);
		$display("%0d results clipped, %0d mismatches", clipped_seen, mismatches);
		if (mismatches == 0)
			$display("PASS principal_axis_rotation_unit");
		else
			$display("FAIL principal_axis_rotation_unit");
		$finish;
	end

endmodule

// File: filelist.f
rtl/par_pkg.sv
rtl/par_stream_if.sv
rtl/par_angle.sv
rtl/par_cordic.sv
rtl/par_combine.sv
rtl/principal_axis_rotation_unit.sv
bench/rotation_checker.sv
bench/tb.sv
